>>> rtl/core/assert_macros.svh
// Assertion helpers used by the scheduler controller.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define SRTF_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define SRTF_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/srtf_pkg.sv
`timescale 1ns / 1ps

package srtf_pkg;

  localparam int MAX_PROCS = 8;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int DATA_W    = 16;
  localparam int TICK_W    = 20;
  localparam int SUM_W     = 23;
  localparam int PIDX_W    = 3;

  // One process entry
  typedef struct packed {
    logic [DATA_W-1:0] arrive_time;
    logic [DATA_W-1:0] burst_time;
    logic              last_entry;
  } srtf_in_t;

  // One completion record
  typedef struct packed {
    logic [PIDX_W-1:0] proc_index;
    logic [DATA_W-1:0] arrive_out;
    logic [DATA_W-1:0] burst_out;
    logic [TICK_W-1:0] turnaround;
    logic [TICK_W-1:0] wait_time;
    logic [SUM_W-1:0]  total_wait;
    logic [SUM_W-1:0]  total_turnaround;
    logic              last_result;
  } srtf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_FIN,
    ST_EMIT
  } srtf_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_init;
    logic scan_step;
    logic apply;
    logic fin;
    logic emit;
  } srtf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_needed;
    logic scan_last;
    logic best_valid;
    logic best_one;
    logic run_last;
  } srtf_stat_t;

endpackage

>>> rtl/core/srtf_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srtf_ctrl import srtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       last_entry_i,
  input  srtf_stat_t stat_i,
  output srtf_cmd_t  cmd_o,
  output logic       busy
);

  srtf_state_e state_q, state_d;
  logic        go_run;
  logic        done_tick;

  assign go_run    = start && last_entry_i && stat_i.run_needed;
  assign done_tick = stat_i.best_valid && stat_i.best_one;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (go_run) state_d = ST_SCAN;
      ST_SCAN:  if (stat_i.scan_last) state_d = ST_APPLY;
      ST_APPLY: state_d = done_tick ? ST_FIN : ST_SCAN;
      ST_FIN:   state_d = ST_EMIT;
      ST_EMIT:  state_d = stat_i.run_last ? ST_IDLE : ST_SCAN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy            = 1'b0;
        cmd_o.load      = start;
        cmd_o.clear     = start && last_entry_i && !stat_i.run_needed;
        cmd_o.scan_init = go_run;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_APPLY: begin
        cmd_o.apply     = 1'b1;
        cmd_o.scan_init = !done_tick;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.clear     = stat_i.run_last;
        cmd_o.scan_init = !stat_i.run_last;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  `SRTF_AST_NEXT(a_run_starts, state_q == ST_IDLE && go_run, busy, "run did not start")
  `SRTF_AST_NEXT(a_emit_exit, state_q == ST_EMIT,
                 state_q == ST_SCAN || state_q == ST_IDLE, "bad exit from emit")
  `SRTF_AST_NEXT(a_finish_path, state_q == ST_APPLY && done_tick,
                 state_q == ST_FIN, "completion not finished")

endmodule

>>> rtl/core/srtf_dpath.sv
`timescale 1ns / 1ps

module srtf_dpath import srtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  srtf_in_t   in_i,
  input  srtf_cmd_t  cmd_i,
  output srtf_stat_t stat_o,
  output srtf_out_t  res_o,
  output logic       res_valid_o
);

  // Process table, valid only for entries loaded in this batch
  logic [DATA_W-1:0] arr_q   [MAX_PROCS];
  logic [DATA_W-1:0] burst_q [MAX_PROCS];
  logic [DATA_W-1:0] rem_q   [MAX_PROCS];

  logic [CNT_W-1:0]  count_q, needed_q, finished_q;
  logic [TICK_W-1:0] tick_q;
  logic [SUM_W-1:0]  wsum_q, tsum_q;
  logic [IDX_W-1:0]  scan_idx_q;
  logic              best_valid_q, nxt_valid_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DATA_W-1:0] best_rem_q, best_arr_q, best_burst_q, nxt_arr_q;
  logic [TICK_W-1:0] ta_q, wt_q;
  srtf_out_t         res_q;
  logic              res_valid_q;

  logic              room;
  logic [DATA_W-1:0] rd_arr, rd_burst, rd_rem;
  logic              live, arrived, take, later;
  logic [TICK_W-1:0] ta_c, wt_c;
  logic [SUM_W-1:0]  wsum_c, tsum_c;

  assign room     = count_q < CNT_W'(MAX_PROCS);
  assign rd_arr   = arr_q[scan_idx_q];
  assign rd_burst = burst_q[scan_idx_q];
  assign rd_rem   = rem_q[scan_idx_q];
  assign live     = rd_rem != '0;
  assign arrived  = TICK_W'(rd_arr) <= tick_q;
  assign take     = live && arrived && (!best_valid_q || rd_rem < best_rem_q);
  assign later    = live && !arrived && (!nxt_valid_q || rd_arr < nxt_arr_q);

  assign ta_c   = tick_q + TICK_W'(1) - TICK_W'(best_arr_q);
  assign wt_c   = ta_c - TICK_W'(best_burst_q);
  assign wsum_c = wsum_q + SUM_W'(wt_q);
  assign tsum_c = tsum_q + SUM_W'(ta_q);

  // Report status
  assign stat_o.run_needed = (needed_q != '0) || (room && in_i.burst_time != '0);
  assign stat_o.scan_last  = (CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q;
  assign stat_o.best_valid = best_valid_q;
  assign stat_o.best_one   = best_rem_q == DATA_W'(1);
  assign stat_o.run_last   = (finished_q + CNT_W'(1)) == needed_q;

  // Write the table: load a new entry or retire one tick of service
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      arr_q[count_q[IDX_W-1:0]]   <= in_i.arrive_time;
      burst_q[count_q[IDX_W-1:0]] <= in_i.burst_time;
      rem_q[count_q[IDX_W-1:0]]   <= in_i.burst_time;
    end else if (cmd_i.apply && best_valid_q) begin
      rem_q[best_idx_q] <= best_rem_q - DATA_W'(1);
    end
  end

  // Hold batch counters, tick and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      needed_q   <= '0;
      finished_q <= '0;
      tick_q     <= '0;
      wsum_q     <= '0;
      tsum_q     <= '0;
    end else if (cmd_i.clear) begin
      count_q    <= '0;
      needed_q   <= '0;
      finished_q <= '0;
      tick_q     <= '0;
      wsum_q     <= '0;
      tsum_q     <= '0;
    end else begin
      if (cmd_i.load && room) begin
        count_q <= count_q + CNT_W'(1);
        if (in_i.burst_time != '0) needed_q <= needed_q + CNT_W'(1);
      end
      if (cmd_i.apply) begin
        if (!best_valid_q) begin
          // nothing ready: skip idle ticks up to the next arrival
          tick_q <= TICK_W'(nxt_arr_q);
        end else if (best_rem_q != DATA_W'(1)) begin
          tick_q <= tick_q + TICK_W'(1);
        end
      end
      if (cmd_i.fin) tick_q <= tick_q + TICK_W'(1);
      if (cmd_i.emit) begin
        finished_q <= finished_q + CNT_W'(1);
        wsum_q     <= wsum_c;
        tsum_q     <= tsum_c;
      end
    end
  end

  // Scan one entry per cycle, keep the best ready and earliest pending entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      best_valid_q <= 1'b0;
      nxt_valid_q  <= 1'b0;
    end else if (cmd_i.scan_init) begin
      scan_idx_q   <= '0;
      best_valid_q <= 1'b0;
      nxt_valid_q  <= 1'b0;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + IDX_W'(1);
      if (take) best_valid_q <= 1'b1;
      if (later) nxt_valid_q <= 1'b1;
    end
  end

  // Capture candidate payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && take) begin
      best_idx_q   <= scan_idx_q;
      best_rem_q   <= rd_rem;
      best_arr_q   <= rd_arr;
      best_burst_q <= rd_burst;
    end
    if (cmd_i.scan_step && later) nxt_arr_q <= rd_arr;
    if (cmd_i.fin) begin
      ta_q <= ta_c;
      wt_q <= wt_c;
    end
    if (cmd_i.emit) begin
      res_q.proc_index       <= PIDX_W'(best_idx_q);
      res_q.arrive_out       <= best_arr_q;
      res_q.burst_out        <= best_burst_q;
      res_q.turnaround       <= ta_q;
      res_q.wait_time        <= wt_q;
      res_q.total_wait       <= wsum_c;
      res_q.total_turnaround <= tsum_c;
      res_q.last_result      <= stat_o.run_last;
    end
  end

  // Strobe each completion transaction for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

>>> rtl/core/srtf_scheduler_unit.sv
`timescale 1ns / 1ps
// Loading: one entry per cycle, start taken whenever busy is low; a non-final entry gives no result.
// Run: each simulated busy tick scans the N loaded entries (one table entry per cycle) and then
// applies it; an idle gap costs one such scan and apply; a completion adds FIN and EMIT states.
// Each result is registered from EMIT, which follows APPLY and FIN; busy drops with the last.
// Reset clears counters, tick, totals and control; the process table is not cleared.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module srtf_scheduler_unit import srtf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  srtf_in_t  in_i,
  output logic      busy,
  output srtf_out_t res_o,
  output logic      res_valid_o
);

  srtf_cmd_t  cmd;
  srtf_stat_t stat;

  srtf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .last_entry_i (in_i.last_entry),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .busy         (busy)
  );

  srtf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srtf_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  srtf_in_t  in_i;
  logic      busy;
  srtf_out_t res_o;
  logic      res_valid_o;

  // Process table as loaded for the current batch
  logic [DATA_W-1:0] tbl_arrive [MAX_PROCS];
  logic [DATA_W-1:0] tbl_burst  [MAX_PROCS];
  logic [DATA_W-1:0] tbl_left   [MAX_PROCS];
  int                loaded;

  srtf_out_t pending_completions [$];
  srtf_out_t expected_rec;
  int        fail_count;
  bit        no_idle;

  srtf_scheduler_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .in_i        (in_i),
    .busy        (busy),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  always #5 clk_i = ~clk_i;

  // Simulate the batch tick by tick and queue one record per completion
  function automatic void run_batch();
    int          needed;
    int          finished;
    int          pick;
    int unsigned tick;
    int unsigned ta;
    int unsigned wt;
    int unsigned wsum;
    int unsigned tsum;
    srtf_out_t   rec;
    needed = 0;
    finished = 0;
    tick = 0;
    wsum = 0;
    tsum = 0;
    for (int i = 0; i < loaded; i++)
      if (tbl_left[i] != 0) needed++;
    while (finished < needed) begin
      pick = -1;
      for (int i = 0; i < loaded; i++) begin
        if (tbl_left[i] != 0 && tbl_arrive[i] <= tick) begin
          if (pick < 0 || tbl_left[i] < tbl_left[pick]) pick = i;
        end
      end
      if (pick >= 0) begin
        tbl_left[pick] = tbl_left[pick] - 1'b1;
        if (tbl_left[pick] == 0) begin
          finished++;
          ta = tick + 1 - tbl_arrive[pick];
          wt = ta - tbl_burst[pick];
          wsum = (wsum + wt) & 32'h7F_FFFF;
          tsum = (tsum + ta) & 32'h7F_FFFF;
          rec.proc_index       = pick[PIDX_W-1:0];
          rec.arrive_out       = tbl_arrive[pick];
          rec.burst_out        = tbl_burst[pick];
          rec.turnaround       = ta[TICK_W-1:0];
          rec.wait_time        = wt[TICK_W-1:0];
          rec.total_wait       = wsum[SUM_W-1:0];
          rec.total_turnaround = tsum[SUM_W-1:0];
          rec.last_result      = (finished == needed);
          pending_completions.push_back(rec);
        end
      end
      tick++;
    end
    loaded = 0;
  endfunction

  // Store an accepted entry; drop it when the table is full
  function automatic void load_entry(input srtf_in_t item);
    if (loaded < MAX_PROCS) begin
      tbl_arrive[loaded] = item.arrive_time;
      tbl_burst[loaded]  = item.burst_time;
      tbl_left[loaded]   = item.burst_time;
      loaded++;
    end
    if (item.last_entry) run_batch();
  endfunction

  // Mostly short gaps, a few long ones, none inside a back-to-back stretch
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold start low with junk on the payload, once per requested idle cycle
  task automatic idle_cycles(input int n);
    srtf_in_t junk;
    repeat (n) begin
      @(negedge clk_i);
      junk.arrive_time = DATA_W'($urandom);
      junk.burst_time  = DATA_W'($urandom);
      junk.last_entry  = 1'($urandom);
      start <= 1'b0;
      in_i  <= junk;
    end
  endtask

  // Drive one entry until the block takes the transaction, then idle
  task automatic send_entry(input logic [DATA_W-1:0] arrive, input logic [DATA_W-1:0] burst,
                            input bit last);
    srtf_in_t item;
    item.arrive_time = arrive;
    item.burst_time  = burst;
    item.last_entry  = last;
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    load_entry(item);
    idle_cycles(next_gap());
  endtask

  // Hold off the sender until every queued completion has come out
  task automatic wait_drained();
    idle_cycles(1);
    while (pending_completions.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare every strobed completion with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      if (pending_completions.size() == 0) begin
        $error("completion with index %0d arrived with none expected", res_o.proc_index);
        fail_count++;
      end else begin
        expected_rec = pending_completions.pop_front();
        check_field("proc_index", 32'(expected_rec.proc_index), 32'(res_o.proc_index));
        check_field("arrive_out", 32'(expected_rec.arrive_out), 32'(res_o.arrive_out));
        check_field("burst_out", 32'(expected_rec.burst_out), 32'(res_o.burst_out));
        check_field("turnaround", 32'(expected_rec.turnaround), 32'(res_o.turnaround));
        check_field("wait_time", 32'(expected_rec.wait_time), 32'(res_o.wait_time));
        check_field("total_wait", 32'(expected_rec.total_wait), 32'(res_o.total_wait));
        check_field("total_turnaround", 32'(expected_rec.total_turnaround),
                    32'(res_o.total_turnaround));
        check_field("last_result", 32'(expected_rec.last_result), 32'(res_o.last_result));
      end
    end
  end

  // One-entry batches at both ends of the arrival range
  task automatic test_single_entries();
    send_entry(16'd0, 16'd1, 1'b1);
    send_entry(16'hFFFF, 16'd1, 1'b1);
  endtask

  // Later shorter jobs preempt a longer running one
  task automatic test_preemption();
    send_entry(16'd0, 16'd8, 1'b0);
    send_entry(16'd1, 16'd4, 1'b0);
    send_entry(16'd2, 16'd9, 1'b0);
    send_entry(16'd3, 16'd5, 1'b1);
  endtask

  // Equal remaining time: lowest index wins
  task automatic test_tie_break();
    send_entry(16'd0, 16'd3, 1'b0);
    send_entry(16'd0, 16'd3, 1'b0);
    send_entry(16'd0, 16'd3, 1'b1);
  endtask

  // A zero-burst entry never completes; a batch of only that gives nothing
  task automatic test_zero_burst();
    send_entry(16'd0, 16'd0, 1'b0);
    send_entry(16'd1, 16'd2, 1'b1);
    send_entry(16'd5, 16'd0, 1'b1);
    wait_drained();
  endtask

  // Overflow entry is dropped but its final mark still starts the run
  task automatic test_table_full();
    for (int k = 0; k < MAX_PROCS; k++)
      send_entry(16'(2 * k), 16'(MAX_PROCS + 1 - k), 1'b0);
    send_entry(16'd0, 16'd1, 1'b1);
  endtask

  // Full-range burst, preempted by a short late arrival
  task automatic test_long_burst();
    send_entry(16'd0, 16'hFFFF, 1'b0);
    send_entry(16'd40000, 16'd3, 1'b1);
  endtask

  function automatic logic [DATA_W-1:0] rand_arrive();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return DATA_W'($urandom_range(0, 65535));
    if (r < 3) return DATA_W'($urandom_range(0, 300));
    return DATA_W'($urandom_range(0, 20));
  endfunction

  function automatic logic [DATA_W-1:0] rand_burst();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return '0;
    if (r < 3) return DATA_W'($urandom_range(50, 300));
    return DATA_W'($urandom_range(1, 12));
  endfunction

  // Random batches, a few overfilled, with drains in between
  task automatic test_random_batches();
    int sent;
    int batch;
    int size;
    sent = 0;
    batch = 0;
    while (sent < 128) begin
      no_idle = ($urandom_range(0, 3) == 0);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3)
                                         : $urandom_range(1, MAX_PROCS);
      for (int k = 0; k < size; k++) begin
        send_entry(rand_arrive(), rand_burst(), k == size - 1);
        sent++;
      end
      no_idle = 1'b0;
      if (batch == 2 || $urandom_range(0, 5) == 0) wait_drained();
      batch++;
    end
    idle_cycles(1);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    loaded = 0;
    fail_count = 0;
    no_idle = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_entries();
    test_preemption();
    test_tie_break();
    test_zero_burst();
    test_table_full();
    test_long_burst();
    test_random_batches();

    // Drain, then allow the tail latency
    while (pending_completions.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("srtf_scheduler_unit: match");
    end else begin
      $display("srtf_scheduler_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("srtf_scheduler_unit: mismatch");
    $finish;
  end

endmodule
